// ----- hdl/tnd_pkg.sv -----
// Shared types and constants of the telnet option decoder.
`timescale 1ns / 1ps
`default_nettype none
package tnd_pkg;

  localparam logic [7:0] TEL_IAC  = 8'hFF;
  localparam logic [7:0] TEL_DO   = 8'hFD;
  localparam logic [7:0] TEL_WONT = 8'hFC;
  localparam logic [7:0] TEL_WILL = 8'hFB;
  localparam logic [7:0] TEL_SB   = 8'hFA;
  localparam logic [7:0] TEL_SE   = 8'hF0;
  localparam logic [7:0] OPT_TTYPE  = 8'h18;
  localparam logic [7:0] TTYPE_SEND = 8'h01;
  localparam logic [7:0] TTYPE_IS   = 8'h00;
  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_LF  = 8'h0A;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_OPT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_NAME = 1'b1;
  localparam logic [7:0]  ACC_OPT_RST   = 8'd24;
  localparam logic [39:0] TERM_NAME_RST = 40'h5654313030;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // reply sequencer index
  localparam int unsigned SEQ_W = 4;
  localparam logic [SEQ_W-1:0] ANS_LAST   = 4'd2;
  localparam logic [SEQ_W-1:0] TTYPE_LAST = 4'd10;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_IAC    = 3'd1,
    MODE_DO     = 3'd2,
    MODE_WILL   = 3'd3,
    MODE_SKIP   = 3'd4,
    MODE_SUB    = 3'd5,
    MODE_SUBIAC = 3'd6
  } tnd_mode_t;

  typedef enum logic [1:0] {
    KIND_APP   = 2'd0,
    KIND_ANS   = 2'd1,
    KIND_TTYPE = 2'd2
  } tnd_kind_t;

  typedef struct packed {
    tnd_kind_t  kind;
    logic [7:0] data;  // app byte or option code
    logic [7:0] verb;  // WILL, WONT or DO for answers
  } tnd_cmd_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               full;
    logic               empty;
  } tnd_qstat_t;

endpackage
`default_nettype wire

// ----- hdl/tnd_if.sv -----
// Request channel interfaces: received bytes in, decoded results out.
`timescale 1ns / 1ps
`default_nettype none
interface tnd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface tnd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       to_peer;
  logic       last;

  modport source (output valid, output out_byte, output to_peer, output last, input ready);
  modport sink (input valid, input out_byte, input to_peer, input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/tnd_front.sv -----
// Front end: telnet parser that turns received bytes into queued commands.
`timescale 1ns / 1ps
`default_nettype none
module tnd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  tnd_in_if.sink              in_ch,
  input  wire logic [7:0]     accepted_option,
  input  wire logic           q_full,
  output logic                push,
  output tnd_pkg::tnd_cmd_t   push_cmd
);
  import tnd_pkg::*;

  tnd_mode_t  mode_r, mode_nxt;
  logic       cr_r, cr_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       match_r, match_nxt;
  logic       fire;
  logic [7:0] c;

  assign in_ch.ready = !q_full;
  assign fire = in_ch.valid && !q_full;
  assign c = in_ch.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      cr_r    <= 1'b0;
      pos_r   <= 2'd0;
      match_r <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      cr_r    <= cr_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    cr_nxt        = cr_r;
    pos_nxt       = pos_r;
    match_nxt     = match_r;
    push          = 1'b0;
    push_cmd.kind = KIND_APP;
    push_cmd.data = c;
    push_cmd.verb = TEL_DO;

    case (mode_r)
      MODE_IAC: begin
        if (c == TEL_IAC) begin
          push     = fire;
          mode_nxt = MODE_NORMAL;
        end else if (c == TEL_DO) begin
          mode_nxt = MODE_DO;
        end else if (c == TEL_WILL) begin
          mode_nxt = MODE_WILL;
        end else if (c == TEL_SB) begin
          mode_nxt  = MODE_SUB;
          pos_nxt   = 2'd0;
          match_nxt = 1'b0;
        end else begin
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_DO: begin
        push          = fire;
        push_cmd.kind = KIND_ANS;
        push_cmd.verb = (c == accepted_option) ? TEL_WILL : TEL_WONT;
        mode_nxt      = MODE_NORMAL;
      end
      MODE_WILL: begin
        push          = fire;
        push_cmd.kind = KIND_ANS;
        push_cmd.verb = TEL_DO;
        mode_nxt      = MODE_NORMAL;
      end
      MODE_SKIP: begin
        mode_nxt = MODE_NORMAL;
      end
      MODE_SUB: begin
        if (c == TEL_IAC) begin
          mode_nxt  = MODE_SUBIAC;
          pos_nxt   = 2'd2;
          match_nxt = 1'b0;
        end else if (pos_r == 2'd0) begin
          match_nxt = (c == OPT_TTYPE);
          pos_nxt   = 2'd1;
        end else if (pos_r == 2'd1) begin
          if (match_r && c == TTYPE_SEND) begin
            push          = fire;
            push_cmd.kind = KIND_TTYPE;
          end
          pos_nxt   = 2'd2;
          match_nxt = 1'b0;
        end
      end
      MODE_SUBIAC: begin
        if (c == TEL_IAC) begin
          push     = fire;
          mode_nxt = MODE_SUB;
        end else if (c == TEL_SE) begin
          mode_nxt = MODE_NORMAL;
        end else begin
          mode_nxt = MODE_SUB;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (c == TEL_IAC) begin
          mode_nxt = MODE_IAC;
          cr_nxt   = 1'b0;
        end else if (cr_r) begin
          // held CR: NUL restores it, LF replaces it, CR keeps it held
          if (c == CHR_NUL) begin
            push          = fire;
            push_cmd.data = CHR_CR;
            cr_nxt        = 1'b0;
          end else if (c != CHR_CR) begin
            push   = fire;
            cr_nxt = 1'b0;
          end
        end else if (c == CHR_CR) begin
          cr_nxt = 1'b1;
        end else begin
          push = fire;
        end
      end
    endcase

    if (in_ch.chunk_end) begin
      mode_nxt  = MODE_NORMAL;
      cr_nxt    = 1'b0;
      pos_nxt   = 2'd0;
      match_nxt = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tnd_queue.sv -----
// Short command queue between the parser and the reply sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tnd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tnd_pkg::tnd_cmd_t  push_cmd,
  input  wire logic               pop,
  output tnd_pkg::tnd_cmd_t       head_cmd,
  output tnd_pkg::tnd_qstat_t     stat
);
  import tnd_pkg::*;

  tnd_cmd_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  assign head_cmd   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule
`default_nettype wire

// ----- hdl/tnd_back.sv -----
// Back end: expands queued commands into result bytes behind an output register.
`timescale 1ns / 1ps
`default_nettype none
module tnd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tnd_pkg::tnd_cmd_t  head_cmd,
  input  wire logic               q_empty,
  input  wire logic [39:0]        term_name,
  output logic                    pop,
  tnd_out_if.source               out_ch
);
  import tnd_pkg::*;

  logic [SEQ_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             to_peer_r, last_r;
  logic             advance;
  logic [7:0]       res_byte;
  logic             res_peer, res_last;

  assign advance = !q_empty && (!out_valid_r || out_ch.ready);
  assign pop     = advance && res_last;
  assign idx_nxt = res_last ? '0 : idx_r + 1'b1;

  always_comb begin
    res_byte = head_cmd.data;
    res_peer = 1'b1;
    res_last = 1'b0;
    case (head_cmd.kind)
      KIND_ANS: begin
        res_last = (idx_r == ANS_LAST);
        case (idx_r)
          4'd0:    res_byte = TEL_IAC;
          4'd1:    res_byte = head_cmd.verb;
          default: res_byte = head_cmd.data;
        endcase
      end
      KIND_TTYPE: begin
        res_last = (idx_r == TTYPE_LAST);
        case (idx_r)
          4'd0:    res_byte = TEL_IAC;
          4'd1:    res_byte = TEL_SB;
          4'd2:    res_byte = OPT_TTYPE;
          4'd3:    res_byte = TTYPE_IS;
          4'd4:    res_byte = term_name[39:32];
          4'd5:    res_byte = term_name[31:24];
          4'd6:    res_byte = term_name[23:16];
          4'd7:    res_byte = term_name[15:8];
          4'd8:    res_byte = term_name[7:0];
          4'd9:    res_byte = TEL_IAC;
          default: res_byte = TEL_SE;
        endcase
      end
      default: begin
        res_peer = 1'b0;
        res_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= res_byte;
      to_peer_r  <= res_peer;
      last_r     <= res_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.to_peer  = to_peer_r;
  assign out_ch.last     = last_r;

endmodule
`default_nettype wire

// ----- hdl/telnet_nvt_option_decoder.sv -----
// Top level of the telnet receive decoder with option negotiation.
//
// in_ch carries received telnet bytes (rx_byte, chunk_end); out_ch carries
// decoded application bytes (to_peer = 0) and negotiation answers
// (to_peer = 1), with last set on the final result of each input byte.
// Both are valid/ready channels; a request moves when both are high.
// cfg_we/cfg_index/cfg_wdata write accepted_option (index 0) and
// terminal_name (index 1); write only while the decoder is idle.
// A byte that yields results is queued as a command, which the reply
// sequencer turns into results in the output register. Plain data runs at
// one byte per cycle while out_ch.ready stays high. A DO/WILL answer is
// 3 bytes and a terminal-type reply 11 bytes, also one byte per cycle.
// A 4-entry command queue decouples the parser from the sequencer, so
// in_ch.ready drops only when that queue is full.
// Receiver stall: the output register holds its result and the queue
// fills; input is then backpressured. Reset (rst_n, synchronous, low)
// empties the queue, clears the parser and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module telnet_nvt_option_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tnd_in_if.sink                               in_ch,
  tnd_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [tnd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tnd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tnd_pkg::*;

  logic [7:0]  acc_opt_r;
  logic [39:0] term_name_r;
  logic        push, pop;
  tnd_cmd_t    push_cmd, head_cmd;
  tnd_qstat_t  q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_opt_r   <= ACC_OPT_RST;
      term_name_r <= TERM_NAME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACC_OPT:   acc_opt_r   <= cfg_wdata[7:0];
        CFG_TERM_NAME: term_name_r <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  tnd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .accepted_option (acc_opt_r),
    .q_full          (q_stat.full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  tnd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  tnd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_empty   (q_stat.empty),
    .term_name (term_name_r),
    .pop       (pop),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // a multi-byte reply is never broken by a bubble
  a_reply_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("gap inside a multi-byte reply");

  // application data is always a single result
  a_app_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.to_peer |-> out_ch.last)
    else $error("application byte without last");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("command queue overflow");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.full)
    else $error("input stalled with room in queue");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_telnet_nvt_option_decoder.sv -----
// Self-checking testbench for the telnet receive decoder: directed table, then random streams.
`timescale 1ns / 1ps
module tb_telnet_nvt_option_decoder;
  import tnd_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       peer;
    logic       last;
  } res_t;

  // rx, chunk_end, typed expectation, typed result present, result byte, to_peer
  typedef struct packed {
    logic [7:0] rx;
    logic       ce;
    logic       typed;
    logic       has_res;
    logic [7:0] res_byte;
    logic       res_peer;
  } dir_row_t;

  localparam int N_DIR = 30;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tnd_in_if  in_bus ();
  tnd_out_if out_bus ();

  telnet_nvt_option_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dir_row_t dir_tab [N_DIR] = '{
    '{8'h41,      1'b0, 1'b1, 1'b1, 8'h41,   1'b0},
    '{TEL_IAC,    1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_IAC,    1'b0, 1'b1, 1'b1, TEL_IAC, 1'b0},  // doubled IAC
    '{CHR_CR,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{CHR_NUL,    1'b0, 1'b1, 1'b1, CHR_CR,  1'b0},
    '{CHR_CR,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{CHR_LF,     1'b0, 1'b1, 1'b1, CHR_LF,  1'b0},
    '{CHR_CR,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{CHR_CR,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},  // CR CR keeps one held
    '{8'h78,      1'b0, 1'b1, 1'b1, 8'h78,   1'b0},
    '{CHR_CR,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_IAC,    1'b0, 1'b1, 1'b0, 8'h00,   1'b0},  // drops the held CR
    '{TEL_DO,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{OPT_TTYPE,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0},
    '{TEL_IAC,    1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_WILL,   1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_IAC,    1'b0, 1'b0, 1'b0, 8'h00,   1'b0},  // option code 255
    '{TEL_IAC,    1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{8'hF1,      1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{8'h41,      1'b0, 1'b1, 1'b0, 8'h00,   1'b0},  // swallowed after other command
    '{TEL_IAC,    1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_SB,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{OPT_TTYPE,  1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TTYPE_SEND, 1'b0, 1'b0, 1'b0, 8'h00,   1'b0},
    '{TEL_IAC,    1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_IAC,    1'b0, 1'b1, 1'b1, TEL_IAC, 1'b0},  // doubled IAC inside SB
    '{TEL_IAC,    1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_SE,     1'b0, 1'b1, 1'b0, 8'h00,   1'b0},
    '{TEL_IAC,    1'b1, 1'b1, 1'b0, 8'h00,   1'b0},  // chunk end clears the IAC
    '{8'h42,      1'b0, 1'b1, 1'b1, 8'h42,   1'b0}
  };

  // decoder model state and registers
  tnd_mode_t   pmode;
  logic        cr_held;
  logic [1:0]  sb_pos;
  logic        sb_ttype;
  logic [7:0]  acc_opt;
  logic [39:0] term_name;

  res_t step_res[$];
  res_t decoded_q[$];

  int errors;
  int fed;
  bit quiet;
  bit hold_req;

  function automatic void emit(input logic [7:0] b, input logic peer);
    step_res.push_back('{b, peer, 1'b0});
  endfunction

  function automatic void decode_rx(input logic [7:0] c, input logic ce, input bit keep);
    step_res.delete();
    case (pmode)
      MODE_IAC: begin
        if (c == TEL_IAC) begin
          emit(TEL_IAC, 1'b0);
          pmode = MODE_NORMAL;
        end else if (c == TEL_DO) begin
          pmode = MODE_DO;
        end else if (c == TEL_WILL) begin
          pmode = MODE_WILL;
        end else if (c == TEL_SB) begin
          pmode = MODE_SUB;
          sb_pos = 2'd0;
          sb_ttype = 1'b0;
        end else begin
          pmode = MODE_SKIP;
        end
      end
      MODE_DO: begin
        emit(TEL_IAC, 1'b1);
        emit((c == acc_opt) ? TEL_WILL : TEL_WONT, 1'b1);
        emit(c, 1'b1);
        pmode = MODE_NORMAL;
      end
      MODE_WILL: begin
        emit(TEL_IAC, 1'b1);
        emit(TEL_DO, 1'b1);
        emit(c, 1'b1);
        pmode = MODE_NORMAL;
      end
      MODE_SKIP: pmode = MODE_NORMAL;
      MODE_SUB: begin
        if (c == TEL_IAC) begin
          pmode = MODE_SUBIAC;
          sb_pos = 2'd2;
          sb_ttype = 1'b0;
        end else if (sb_pos == 2'd0) begin
          sb_ttype = (c == OPT_TTYPE);
          sb_pos = 2'd1;
        end else if (sb_pos == 2'd1) begin
          if (sb_ttype && c == TTYPE_SEND) begin
            emit(TEL_IAC, 1'b1);
            emit(TEL_SB, 1'b1);
            emit(OPT_TTYPE, 1'b1);
            emit(TTYPE_IS, 1'b1);
            for (int i = 4; i >= 0; i--) emit(term_name[8*i +: 8], 1'b1);
            emit(TEL_IAC, 1'b1);
            emit(TEL_SE, 1'b1);
          end
          sb_pos = 2'd2;
          sb_ttype = 1'b0;
        end
      end
      MODE_SUBIAC: begin
        if (c == TEL_IAC) begin
          emit(TEL_IAC, 1'b0);
          pmode = MODE_SUB;
        end else if (c == TEL_SE) begin
          pmode = MODE_NORMAL;
        end else begin
          pmode = MODE_SUB;
        end
      end
      default: begin
        pmode = MODE_NORMAL;
        if (c == TEL_IAC) begin
          pmode = MODE_IAC;
          cr_held = 1'b0;
        end else if (cr_held) begin
          if (c == CHR_NUL) begin
            emit(CHR_CR, 1'b0);
            cr_held = 1'b0;
          end else if (c == CHR_LF) begin
            emit(CHR_LF, 1'b0);
            cr_held = 1'b0;
          end else if (c != CHR_CR) begin
            emit(c, 1'b0);
            cr_held = 1'b0;
          end
        end else if (c == CHR_CR) begin
          cr_held = 1'b1;
        end else begin
          emit(c, 1'b0);
        end
      end
    endcase
    if (step_res.size() > 0) step_res[$].last = 1'b1;
    if (keep) foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    if (ce) begin
      pmode = MODE_NORMAL;
      cr_held = 1'b0;
      sb_pos = 2'd0;
      sb_ttype = 1'b0;
    end
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void note_bad(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  task automatic send_rx(input logic [7:0] b, input logic ce);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.rx_byte   <= b;
    in_bus.chunk_end <= ce;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic feed(input logic [7:0] b);
    logic ce;
    ce = ($urandom_range(0, 19) == 0);
    send_rx(b, ce);
    decode_rx(b, ce, 1'b1);
    fed++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    if (idx == CFG_ACC_OPT) acc_opt = d[7:0];
    else term_name = d[39:0];
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("** telnet_nvt_option_decoder: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int   stall_left;
    res_t got;
    res_t want;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got = '{out_bus.out_byte, out_bus.to_peer, out_bus.last};
        if (decoded_q.size() == 0) begin
          note_bad($sformatf("unexpected result: byte %02h to_peer %0b last %0b",
                             got.b, got.peer, got.last));
        end else begin
          want = decoded_q.pop_front();
          if (got !== want)
            note_bad($sformatf(
              "mismatch: expected byte %02h to_peer %0b last %0b, got %02h %0b %0b",
              want.b, want.peer, want.last, got.b, got.peer, got.last));
        end
      end
      // long hold-off so the command queue fills and input backs up
      if (hold_req) begin
        stall_left = 200;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!quiet) stall_left = pick_gap();
      end
    end
  end

  initial begin : stim
    int          r;
    int          k;
    logic [7:0]  opt;
    logic [39:0] name;
    logic [7:0]  cmd;
    errors   = 0;
    fed      = 0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.rx_byte   <= 8'h00;
    in_bus.chunk_end <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ACC_OPT;
    cfg_wdata        <= '0;
    acc_opt   = ACC_OPT_RST;
    term_name = TERM_NAME_RST;
    pmode     = MODE_NORMAL;
    cr_held   = 1'b0;
    sb_pos    = 2'd0;
    sb_ttype  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_rx(dir_tab[i].rx, dir_tab[i].ce);
      decode_rx(dir_tab[i].rx, dir_tab[i].ce, !dir_tab[i].typed);
      if (dir_tab[i].typed && dir_tab[i].has_res)
        decoded_q.push_back('{dir_tab[i].res_byte, dir_tab[i].res_peer, 1'b1});
    end

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          opt  = 8'h00;
          name = 40'h0;
        end
        1: begin
          opt  = 8'hFF;
          name = '1;
        end
        3: begin
          opt  = ACC_OPT_RST;
          name = TERM_NAME_RST;
        end
        default: begin
          opt  = 8'($urandom);
          name = {8'($urandom), 32'($urandom)};
        end
      endcase
      write_cfg(CFG_ACC_OPT, {32'h0, opt});
      write_cfg(CFG_TERM_NAME, name);
      cfg_we   <= 1'b0;
      quiet    = (ph == 3);
      hold_req = (ph == 2);
      fed      = 0;
      while (fed < 64) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          feed(8'($urandom_range(0, 254)));
        end else if (r < 40) begin
          feed(CHR_CR);
          k = $urandom_range(0, 3);
          feed(k == 0 ? CHR_NUL : k == 1 ? CHR_LF : k == 2 ? CHR_CR
                      : 8'($urandom_range(0, 254)));
        end else if (r < 50) begin
          feed(TEL_IAC);
          feed(TEL_DO);
          feed($urandom_range(0, 1) ? acc_opt : 8'($urandom));
        end else if (r < 58) begin
          feed(TEL_IAC);
          feed(TEL_WILL);
          feed(8'($urandom));
        end else if (r < 64) begin
          do cmd = 8'($urandom);
          while (cmd == TEL_IAC || cmd == TEL_DO || cmd == TEL_WILL || cmd == TEL_SB);
          feed(TEL_IAC);
          feed(cmd);
          feed(8'($urandom));
        end else if (r < 70) begin
          feed(TEL_IAC);
          feed(TEL_IAC);
        end else if (r < 85) begin
          feed(TEL_IAC);
          feed(TEL_SB);
          if ($urandom_range(0, 1)) begin
            feed(OPT_TTYPE);
            feed(TTYPE_SEND);
          end else begin
            feed(8'($urandom_range(0, 254)));
            feed(8'($urandom_range(0, 254)));
          end
          k = $urandom_range(0, 4);
          repeat (k) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
              feed(TEL_IAC);
              feed(TEL_IAC);
            end else if (r == 1) begin
              feed(TEL_IAC);
              feed(8'($urandom_range(241, 254)));
            end else begin
              feed(8'($urandom_range(0, 254)));
            end
          end
          feed(TEL_IAC);
          feed(TEL_SE);
        end else begin
          feed(8'($urandom));
        end
      end
    end

    in_bus.valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** telnet_nvt_option_decoder: PASSED **");
    end else begin
      $display("** telnet_nvt_option_decoder: FAILED **");
    end
    $finish;
  end

endmodule
